// ===== rtl/core/qpe_pkg.sv =====
// Shared types, character codes and helpers for the quoted-printable encoder.
`default_nettype none
package qpe_pkg;

  // Reset value of the soft line break limit.
  localparam logic [7:0] SOFT_BREAK_RESET = 8'd71;

  // Largest number of output words that one input word can cause.
  localparam int unsigned MAX_RUN = 6;

  // Character codes used by the encoder.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_LOW   = 8'd33;
  localparam logic [7:0] CH_HIGH  = 8'd126;

  // Held whitespace codes; the spare code behaves as a held tab.
  localparam logic [1:0] HELD_NONE  = 2'd0;
  localparam logic [1:0] HELD_SPACE = 2'd1;
  localparam logic [1:0] HELD_TAB   = 2'd2;

  // Everything the encoder decides for one input word.
  typedef struct packed {
    logic [MAX_RUN-1:0][7:0] bytes;
    logic [2:0]              len;
    logic [1:0]              held;
    logic [7:0]              column;
  } enc_result_t;

  // Upper-case hex digit for one nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    case (nib)
      4'h0: d = "0";
      4'h1: d = "1";
      4'h2: d = "2";
      4'h3: d = "3";
      4'h4: d = "4";
      4'h5: d = "5";
      4'h6: d = "6";
      4'h7: d = "7";
      4'h8: d = "8";
      4'h9: d = "9";
      4'hA: d = "A";
      4'hB: d = "B";
      4'hC: d = "C";
      4'hD: d = "D";
      4'hE: d = "E";
      default: d = "F";
    endcase
    return d;
  endfunction

  // Character that a held whitespace code stands for.
  function automatic logic [7:0] held_char(input logic [1:0] held);
    return (held == HELD_SPACE) ? CH_SPACE : CH_TAB;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/qpe_if.sv =====
// Handshake channels of the quoted-printable encoder: raw input, coded output, limit.
`default_nettype none
interface qpe_raw_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  logic       end_of_text;
  modport source (output valid, output raw_byte, output end_of_text, input ready);
  modport sink   (input valid, input raw_byte, input end_of_text, output ready);
endinterface

interface qpe_coded_if;
  logic       valid;
  logic       ready;
  logic [7:0] coded_byte;
  logic       last_of_run;
  modport source (output valid, output coded_byte, output last_of_run, input ready);
  modport sink   (input valid, input coded_byte, input last_of_run, output ready);
endinterface

interface qpe_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] soft_break_after;
  modport source (output valid, output soft_break_after, input ready);
  modport sink   (input valid, input soft_break_after, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/quoted_printable_encoder_unit.sv =====
// Quoted-printable encoder: one raw word in, zero to six coded words out.
// A word is held in the input register, encoded combinationally and loaded into the run buffer,
// whose front word drives the output. The single output port of the run buffer sends one coded
// word per cycle while the receiver is ready; a new run can load as the final word leaves.
// Reset (synchronous, rst high): input register and run buffer empty, nothing held,
// column count zero, soft break limit 71.
`default_nettype none
module quoted_printable_encoder_unit (
  input  wire logic   clk,
  input  wire logic   rst,
  qpe_raw_if.sink     raw,
  qpe_coded_if.source coded,
  qpe_cfg_if.sink     cfg
);

  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 in_last;
  logic [1:0]           held;
  logic [7:0]           column;
  logic [7:0]           limit;
  logic                 ser_free;
  logic                 consume;
  logic                 load;
  qpe_pkg::enc_result_t run;

  // Encode the registered word against the current line state.
  qpe_format u_format (
    .raw_byte    (in_byte),
    .end_of_text (in_last),
    .held        (held),
    .column      (column),
    .limit       (limit),
    .result      (run)
  );

  // Runs with no words retire without touching the buffer.
  assign consume   = in_valid && ((run.len == 3'd0) || ser_free);
  assign load      = consume && (run.len != 3'd0);
  assign raw.ready = !in_valid || consume;
  assign cfg.ready = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (raw.ready) begin
      in_valid <= raw.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (raw.valid && raw.ready) begin
      in_byte <= raw.raw_byte;
      in_last <= raw.end_of_text;
    end
  end

  // Line state advances as each word retires.
  always_ff @(posedge clk) begin
    if (rst) begin
      held   <= qpe_pkg::HELD_NONE;
      column <= '0;
    end else if (consume) begin
      held   <= run.held;
      column <= run.column;
    end
  end

  // Soft break limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= qpe_pkg::SOFT_BREAK_RESET;
    end else if (cfg.valid && cfg.ready) begin
      limit <= cfg.soft_break_after;
    end
  end

  qpe_serializer u_serializer (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .run   (run),
    .free  (ser_free),
    .coded (coded)
  );

endmodule
`default_nettype wire

// ===== rtl/core/qpe_format.sv =====
// Combinational encoder: one raw word plus line state in, up to six coded words out.
`default_nettype none
module qpe_format (
  input  wire logic [7:0]          raw_byte,
  input  wire logic                end_of_text,
  input  wire logic [1:0]          held,
  input  wire logic [7:0]          column,
  input  wire logic [7:0]          limit,
  output qpe_pkg::enc_result_t     result
);

  logic [7:0] slot [8];
  logic [3:0] k;
  logic [8:0] n;
  logic [1:0] h;
  logic       is_ws;
  logic       is_brk;
  logic       is_esc;

  // Classify the incoming word.
  assign is_ws  = (raw_byte == qpe_pkg::CH_SPACE) || (raw_byte == qpe_pkg::CH_TAB);
  assign is_brk = (raw_byte == qpe_pkg::CH_CR) || (raw_byte == qpe_pkg::CH_LF);
  assign is_esc = (raw_byte > qpe_pkg::CH_HIGH) || (raw_byte < qpe_pkg::CH_LOW) ||
                  (raw_byte == qpe_pkg::CH_EQUAL);

  // Build the output run in order, appending one word at a time.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      slot[i] = '0;
    end
    k = '0;
    n = {1'b0, column};
    h = held;

    if (is_ws) begin
      if (h != qpe_pkg::HELD_NONE) begin
        slot[k[2:0]] = qpe_pkg::held_char(h);
        k = k + 4'd1;
        n = n + 9'd1;
      end
      h = (raw_byte == qpe_pkg::CH_SPACE) ? qpe_pkg::HELD_SPACE : qpe_pkg::HELD_TAB;
    end else if (is_brk) begin
      if (h != qpe_pkg::HELD_NONE) begin
        slot[k[2:0]] = qpe_pkg::CH_EQUAL;
        k = k + 4'd1;
        slot[k[2:0]] = qpe_pkg::hex_digit(qpe_pkg::held_char(h)[7:4]);
        k = k + 4'd1;
        slot[k[2:0]] = qpe_pkg::hex_digit(qpe_pkg::held_char(h)[3:0]);
        k = k + 4'd1;
        h = qpe_pkg::HELD_NONE;
      end
      slot[k[2:0]] = raw_byte;
      k = k + 4'd1;
      n = '0;
    end else begin
      if (h != qpe_pkg::HELD_NONE) begin
        slot[k[2:0]] = qpe_pkg::held_char(h);
        k = k + 4'd1;
        n = n + 9'd1;
        h = qpe_pkg::HELD_NONE;
      end
      if (is_esc) begin
        slot[k[2:0]] = qpe_pkg::CH_EQUAL;
        k = k + 4'd1;
        slot[k[2:0]] = qpe_pkg::hex_digit(raw_byte[7:4]);
        k = k + 4'd1;
        slot[k[2:0]] = qpe_pkg::hex_digit(raw_byte[3:0]);
        k = k + 4'd1;
        n = n + 9'd3;
      end else begin
        slot[k[2:0]] = raw_byte;
        k = k + 4'd1;
        n = n + 9'd1;
      end
    end

    // Soft line break once the line grows past the limit.
    if (n > {1'b0, limit}) begin
      if (h != qpe_pkg::HELD_NONE) begin
        slot[k[2:0]] = qpe_pkg::held_char(h);
        k = k + 4'd1;
        h = qpe_pkg::HELD_NONE;
      end
      slot[k[2:0]] = qpe_pkg::CH_EQUAL;
      k = k + 4'd1;
      slot[k[2:0]] = qpe_pkg::CH_LF;
      k = k + 4'd1;
      n = '0;
    end

    // End of text flushes held whitespace in escaped form.
    if (end_of_text) begin
      if (h != qpe_pkg::HELD_NONE) begin
        slot[k[2:0]] = qpe_pkg::CH_EQUAL;
        k = k + 4'd1;
        slot[k[2:0]] = qpe_pkg::hex_digit(qpe_pkg::held_char(h)[7:4]);
        k = k + 4'd1;
        slot[k[2:0]] = qpe_pkg::hex_digit(qpe_pkg::held_char(h)[3:0]);
        k = k + 4'd1;
        h = qpe_pkg::HELD_NONE;
      end
      n = '0;
    end

    for (int i = 0; i < qpe_pkg::MAX_RUN; i++) begin
      result.bytes[i] = slot[i];
    end
    result.len    = (k > 4'(qpe_pkg::MAX_RUN)) ? 3'(qpe_pkg::MAX_RUN) : k[2:0];
    result.held   = h;
    result.column = n[7:0];
  end

endmodule
`default_nettype wire

// ===== rtl/core/qpe_serializer.sv =====
// Run buffer that holds one encoded run and shifts it out one word per cycle while the output is taken.
`default_nettype none
module qpe_serializer (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire qpe_pkg::enc_result_t run,
  output logic                      free,
  qpe_coded_if.source               coded
);

  logic [qpe_pkg::MAX_RUN-1:0][7:0] buffer;
  logic [2:0]                       count;
  logic                             take;

  assign take = coded.valid && coded.ready;

  // The buffer can take a new run when empty or when its final word leaves now.
  assign free = (count == 3'd0) || (take && (count == 3'd1));

  assign coded.valid       = (count != 3'd0);
  assign coded.coded_byte  = buffer[0];
  assign coded.last_of_run = (count == 3'd1);

  // Word count of the run still waiting.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= run.len;
    end else if (take) begin
      count <= count - 3'd1;
    end
  end

  // Run words; the front word is the one on the output.
  always_ff @(posedge clk) begin
    if (load) begin
      buffer <= run.bytes;
    end else if (take) begin
      for (int i = 0; i < qpe_pkg::MAX_RUN - 1; i++) begin
        buffer[i] <= buffer[i+1];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/qpe_checker.sv =====
// Port-level checks for the quoted-printable encoder and their binding to the top level.
`default_nettype none
module qpe_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       raw_ready,
  input wire logic       coded_valid,
  input wire logic       coded_ready,
  input wire logic [7:0] coded_byte,
  input wire logic       last_of_run
);

  // Reset empties the output side.
  a_reset_empty: assert property (@(posedge clk) rst |=> !coded_valid)
    else $error("coded word valid right after reset");

  // Reset leaves the input side open.
  a_reset_ready: assert property (@(posedge clk) rst |=> raw_ready)
    else $error("input not ready right after reset");

  // A stalled coded word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    coded_valid && !coded_ready |=>
      coded_valid && $stable(coded_byte) && $stable(last_of_run))
    else $error("stalled coded word changed");

  // A run never ends on an escape mark: digits or a line feed always follow.
  a_no_dangling_equal: assert property (@(posedge clk) disable iff (rst)
    coded_valid && last_of_run |-> coded_byte != qpe_pkg::CH_EQUAL)
    else $error("run ends on an escape mark");

endmodule

bind quoted_printable_encoder_unit qpe_checker u_qpe_checker (
  .clk         (clk),
  .rst         (rst),
  .raw_ready   (raw.ready),
  .coded_valid (coded.valid),
  .coded_ready (coded.ready),
  .coded_byte  (coded.coded_byte),
  .last_of_run (coded.last_of_run)
);
`default_nettype wire

// ===== tb/qpe_coded_check.sv =====
// Checker for the quoted-printable encoder: predicts the coded words and compares them.
module qpe_coded_check (
  input  wire logic clk,
  input  wire logic rst,
  qpe_raw_if        raw,
  qpe_coded_if      coded,
  qpe_cfg_if        cfg,
  output int        mismatches,
  output int        words_due,
  output int        coded_seen,
  output int        soft_breaks
);

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } coded_word_t;

  // Expected coded words, oldest first.
  coded_word_t coded_due [$];

  // Own copy of the encoder state and its limit register.
  logic [7:0] break_limit;
  logic [1:0] held;
  logic [7:0] column;

  // Bytes produced for the raw word under prediction.
  logic [7:0] run_bytes [$];

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h41 + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] held_ascii();
    return (held == qpe_pkg::HELD_SPACE) ? qpe_pkg::CH_SPACE : qpe_pkg::CH_TAB;
  endfunction

  function automatic void put_escaped(input logic [7:0] b);
    run_bytes.push_back(qpe_pkg::CH_EQUAL);
    run_bytes.push_back(hex_ascii(b[7:4]));
    run_bytes.push_back(hex_ascii(b[3:0]));
  endfunction

  // Works out the coded words that one raw word causes and queues them.
  function automatic void encode_word(input logic [7:0] ch, input logic eot);
    logic [8:0] n;
    int count;
    coded_word_t w;
    run_bytes.delete();
    n = {1'b0, column};
    if (ch == qpe_pkg::CH_SPACE || ch == qpe_pkg::CH_TAB) begin
      // A new whitespace releases the one already held, raw.
      if (held != qpe_pkg::HELD_NONE) begin
        run_bytes.push_back(held_ascii());
        n++;
      end
      held = (ch == qpe_pkg::CH_SPACE) ? qpe_pkg::HELD_SPACE : qpe_pkg::HELD_TAB;
    end else if (ch == qpe_pkg::CH_CR || ch == qpe_pkg::CH_LF) begin
      // Whitespace before a line break must be escaped.
      if (held != qpe_pkg::HELD_NONE) begin
        put_escaped(held_ascii());
        held = qpe_pkg::HELD_NONE;
      end
      run_bytes.push_back(ch);
      n = '0;
    end else begin
      if (held != qpe_pkg::HELD_NONE) begin
        run_bytes.push_back(held_ascii());
        n++;
        held = qpe_pkg::HELD_NONE;
      end
      if (ch > qpe_pkg::CH_HIGH || ch < qpe_pkg::CH_LOW || ch == qpe_pkg::CH_EQUAL) begin
        put_escaped(ch);
        n += 9'd3;
      end else begin
        run_bytes.push_back(ch);
        n++;
      end
    end

    // Soft line break once the line is too long.
    if (n > {1'b0, break_limit}) begin
      if (held != qpe_pkg::HELD_NONE) begin
        run_bytes.push_back(held_ascii());
        held = qpe_pkg::HELD_NONE;
      end
      run_bytes.push_back(qpe_pkg::CH_EQUAL);
      run_bytes.push_back(qpe_pkg::CH_LF);
      n = '0;
      soft_breaks++;
    end

    // End of text flushes held whitespace as an escape and resets the column count.
    if (eot) begin
      if (held != qpe_pkg::HELD_NONE) begin
        put_escaped(held_ascii());
        held = qpe_pkg::HELD_NONE;
      end
      n = '0;
    end
    column = n[7:0];

    count = (run_bytes.size() > qpe_pkg::MAX_RUN) ? qpe_pkg::MAX_RUN : run_bytes.size();
    for (int k = 0; k < count; k++) begin
      w.code = run_bytes[k];
      w.last = (k == count - 1);
      coded_due.push_back(w);
    end
  endfunction

  // Watch the three channels at each rising edge.
  always @(posedge clk) begin
    coded_word_t want;
    if (rst) begin
      break_limit = qpe_pkg::SOFT_BREAK_RESET;
      held = qpe_pkg::HELD_NONE;
      column = '0;
      coded_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        break_limit = cfg.soft_break_after;
      end

      if (coded.valid && coded.ready) begin
        coded_seen++;
        if (coded_due.size() == 0) begin
          $display("%0t: coded word expected none, actual %h (last %b)",
                   $time, coded.coded_byte, coded.last_of_run);
          mismatches++;
        end else begin
          want = coded_due.pop_front();
          if (want.code !== coded.coded_byte) begin
            $display("%0t: coded_byte expected %h, actual %h",
                     $time, want.code, coded.coded_byte);
            mismatches++;
          end
          if (want.last !== coded.last_of_run) begin
            $display("%0t: last_of_run expected %b, actual %b",
                     $time, want.last, coded.last_of_run);
            mismatches++;
          end
        end
      end

      if (raw.valid && raw.ready) begin
        encode_word(raw.raw_byte, raw.end_of_text);
      end
    end
    words_due = coded_due.size();
  end

endmodule

// ===== tb/quoted_printable_encoder_unit_test.sv =====
// Top of the encoder test: clock, reset, raw text stimulus, limit writes and the verdict.
module quoted_printable_encoder_unit_test;

  // Cycles without any word moving before the run is declared hung.
  localparam int QUIET_LIMIT = 1000;

  logic clk;
  logic rst;

  qpe_raw_if   raw ();
  qpe_coded_if coded ();
  qpe_cfg_if   cfg ();

  int mismatches;
  int words_due;
  int coded_seen;
  int soft_breaks;
  int raw_sent;
  int limit_writes;
  int send_idle;
  int recv_idle;
  int quiet_cycles;

  quoted_printable_encoder_unit dut (
    .clk   (clk),
    .rst   (rst),
    .raw   (raw),
    .coded (coded),
    .cfg   (cfg)
  );

  qpe_coded_check coded_check (
    .clk         (clk),
    .rst         (rst),
    .raw         (raw),
    .coded       (coded),
    .cfg         (cfg),
    .mismatches  (mismatches),
    .words_due   (words_due),
    .coded_seen  (coded_seen),
    .soft_breaks (soft_breaks)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver side: ready drops at random according to the current idle rate.
  always @(negedge clk) begin
    coded.ready = ($urandom_range(99) >= recv_idle);
  end

  // Watchdog on cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if ((raw.valid && raw.ready) || (coded.valid && coded.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offers one raw word, after a random gap, and waits until it is taken.
  task automatic send_word(input logic [7:0] b, input logic eot);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      raw.valid = 1'b0;
      @(negedge clk);
    end
    raw.valid = 1'b1;
    raw.raw_byte = b;
    raw.end_of_text = eot;
    do @(posedge clk); while (!raw.ready);
    raw_sent++;
  endtask

  // Writes the soft break limit once the encoder has gone quiet.
  task automatic write_limit(input logic [7:0] v);
    @(negedge clk);
    raw.valid = 1'b0;
    while (words_due != 0) @(negedge clk);
    // A word that only held whitespace may still be in flight.
    repeat (8) @(negedge clk);
    cfg.valid = 1'b1;
    cfg.soft_break_after = v;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid = 1'b0;
    limit_writes++;
  endtask

  // Random text byte; long lines favor escapes and carry no line breaks.
  function automatic logic [7:0] pick_byte(input bit long_line);
    int r;
    r = $urandom_range(99);
    if (long_line) begin
      if (r < 30) return 8'($urandom_range(33, 126));
      if (r < 40) return (r < 35) ? qpe_pkg::CH_SPACE : qpe_pkg::CH_TAB;
      return 8'($urandom_range(128, 255));
    end
    if (r < 45) return 8'($urandom_range(33, 126));
    if (r < 65) return (r < 55) ? qpe_pkg::CH_SPACE : qpe_pkg::CH_TAB;
    if (r < 73) return (r < 69) ? qpe_pkg::CH_CR : qpe_pkg::CH_LF;
    return 8'($urandom_range(255));
  endfunction

  initial begin
    bit long_line;
    logic [7:0] limit;
    rst = 1'b1;
    raw.valid = 1'b0;
    raw.raw_byte = '0;
    raw.end_of_text = 1'b0;
    coded.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.soft_break_after = '0;
    send_idle = 19;
    recv_idle = 55;
    quiet_cycles = 0;
    raw_sent = 0;
    limit_writes = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed text under the reset limit: plain bytes, escapes at both ends.
    send_word("A", 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(qpe_pkg::CH_EQUAL, 1'b0);
    send_word(qpe_pkg::CH_HIGH, 1'b0);
    send_word(qpe_pkg::CH_LOW, 1'b0);
    send_word(8'h7F, 1'b0);
    // Held whitespace followed by whitespace, by a plain byte, by line breaks.
    send_word(qpe_pkg::CH_SPACE, 1'b0);
    send_word(qpe_pkg::CH_SPACE, 1'b0);
    send_word("x", 1'b0);
    send_word(qpe_pkg::CH_TAB, 1'b0);
    send_word(qpe_pkg::CH_CR, 1'b0);
    send_word(qpe_pkg::CH_SPACE, 1'b0);
    send_word(qpe_pkg::CH_TAB, 1'b0);
    send_word(qpe_pkg::CH_LF, 1'b0);
    // End of text with and without held whitespace.
    send_word(qpe_pkg::CH_SPACE, 1'b1);
    send_word("B", 1'b1);

    // Short lines: a soft break right after released whitespace and an escape,
    // then one where the break itself releases the held whitespace.
    write_limit(8'd8);
    send_word(8'h80, 1'b0);
    send_word(8'h81, 1'b0);
    send_word(qpe_pkg::CH_SPACE, 1'b0);
    send_word(8'h82, 1'b0);
    send_word(8'h90, 1'b0);
    send_word(8'h91, 1'b0);
    send_word("a", 1'b0);
    send_word("b", 1'b0);
    send_word(qpe_pkg::CH_SPACE, 1'b0);
    send_word(qpe_pkg::CH_SPACE, 1'b1);

    // Random text over several limits and idle patterns.
    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        send_idle = 55;
        recv_idle = 19;
      end else if (seg == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (seg)
        0: limit = 8'd8;
        1: limit = 8'd240;
        3: limit = qpe_pkg::SOFT_BREAK_RESET;
        default: limit = 8'($urandom_range(8, 240));
      endcase
      write_limit(limit);
      long_line = (seg == 1);
      repeat (long_line ? 130 : 40) begin
        send_word(pick_byte(long_line), !long_line && ($urandom_range(29) == 0));
      end
    end

    @(negedge clk);
    raw.valid = 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Sent %0d raw words across %0d limit writes and three idle patterns.",
             raw_sent, limit_writes);
    $display("Checked %0d coded words including %0d soft line breaks.",
             coded_seen, soft_breaks);
    if (mismatches == 0 && words_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
